// ===== hdl/hgrp_pkg.sv =====
// Package for the HTTP GET request parser: codes, field types, the
// classified byte record and the keyword character tables.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hgrp_pkg;

    // Bytes taken per connection before overflow is flagged (64..4095)
    localparam int unsigned BUFFER_BYTES = 2048;
    localparam int unsigned BYTE_CNT_W   = 12;
    localparam logic [BYTE_CNT_W-1:0] BUFFER_LIMIT = BYTE_CNT_W'(BUFFER_BYTES);

    // Queue between the classifier and the engine
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Keyword lengths
    localparam logic [3:0] GET_LEN  = 4'd3;
    localparam logic [3:0] ABS_LEN  = 4'd7;
    localparam logic [3:0] VER_LEN  = 4'd8;
    localparam logic [2:0] HOST_LEN = 3'd5;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_H     = 8'h68;

    typedef enum logic {
        KIND_BYTE    = 1'b0,
        KIND_RESTART = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_PENDING  = 2'd0,
        ST_COMPLETE = 2'd1,
        ST_BAD      = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic {
        PH_REQUEST = 1'b0,
        PH_HEADERS = 1'b1
    } phase_t;

    typedef enum logic [2:0] {
        FLD_METHOD  = 3'd0,
        FLD_BLANK1  = 3'd1,
        FLD_URL     = 3'd2,
        FLD_BLANK2  = 3'd3,
        FLD_VERSION = 3'd4,
        FLD_REJECT  = 3'd5
    } line_field_t;

    typedef enum logic [1:0] {
        URL_NONE = 2'd0,
        URL_GOOD = 2'd1,
        URL_ABS  = 2'd2,
        URL_BAD  = 2'd3
    } url_mode_t;

    // One request after classification
    typedef struct packed {
        logic       restart;
        logic [7:0] low;
        logic       blank;
        logic       cr;
        logic       lf;
        logic       nul;
        logic       slash;
        logic       letter_h;
    } item_t;

    function automatic logic [7:0] low_case(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A) begin
            r = b + 8'd32;
        end
        return r;
    endfunction

    function automatic logic [7:0] get_char(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0:    c = 8'h67; // g
            2'd1:    c = 8'h65; // e
            2'd2:    c = 8'h74; // t
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] abs_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h68; // h
            3'd1:    c = 8'h74; // t
            3'd2:    c = 8'h74; // t
            3'd3:    c = 8'h70; // p
            3'd4:    c = 8'h3A; // :
            3'd5:    c = 8'h2F; // /
            3'd6:    c = 8'h2F; // /
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] ver_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h68; // h
            3'd1:    c = 8'h74; // t
            3'd2:    c = 8'h74; // t
            3'd3:    c = 8'h70; // p
            3'd4:    c = 8'h2F; // /
            3'd5:    c = 8'h31; // 1
            3'd6:    c = 8'h2E; // .
            default: c = 8'h31; // 1
        endcase
        return c;
    endfunction

    function automatic logic [7:0] host_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h68; // h
            3'd1:    c = 8'h6F; // o
            3'd2:    c = 8'h73; // s
            3'd3:    c = 8'h74; // t
            3'd4:    c = 8'h3A; // :
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/hgrp_req_if.sv =====
// Request channel of the HTTP GET request parser: valid/ready plus payload.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface hgrp_req_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

`default_nettype wire

// ===== hdl/hgrp_res_if.sv =====
// Result channel of the HTTP GET request parser: valid/ready plus payload.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface hgrp_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       line_end;
    logic       in_headers;
    logic       host_seen;

    modport source (output valid, output status, output line_end,
                    output in_headers, output host_seen, input ready);
    modport sink   (input valid, input status, input line_end,
                    input in_headers, input host_seen, output ready);
endinterface

`default_nettype wire

// ===== hdl/http_get_request_parser.sv =====
// Top level of the HTTP GET request parser: front end, queue and engine.
// Depends on hgrp_pkg, hgrp_req_if, hgrp_res_if, hgrp_front, hgrp_queue, hgrp_engine.
`timescale 1ns / 1ps
`default_nettype none

// Byte-serial HTTP GET request checker. Send one request per byte of the
// incoming stream (kind 0 with data_byte), or kind 1 to restart for a new
// connection; every request returns exactly one result carrying the running
// status (pending, complete GET, bad request, buffer overflow), a flag for
// the LF that closed a CRLF line, and sticky in_headers and host_seen flags.
// Throughput is one request per clock while the result side is ready: the
// front end classifies a byte in the cycle it is accepted and writes it
// into a four-entry queue, and the engine pops one byte per cycle into its
// output register. A result is presented from the output register once its
// request has passed through the queue. Stalls on the result side fill the
// queue and then drop ready on the request side; once a final status is
// reached, bytes are still accepted and answered with that status until a
// restart arrives.

module http_get_request_parser (
    input  wire logic  clk,
    input  wire logic  rst_n,
    hgrp_req_if.sink   req,
    hgrp_res_if.source res
);
    import hgrp_pkg::*;

    item_t push_item;
    item_t pop_item;
    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_empty;

    // Classify and enqueue incoming requests
    hgrp_front u_front (
        .req       (req),
        .q_full    (q_full),
        .push_item (push_item),
        .push      (push)
    );

    // Decouple the front end from the engine
    hgrp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Parse and register the result
    hgrp_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (pop_item),
        .q_empty (q_empty),
        .pop     (pop),
        .res     (res)
    );

endmodule

`default_nettype wire

// ===== hdl/hgrp_front.sv =====
// Front end: takes requests and classifies each byte for the engine.
// Depends on hgrp_pkg and hgrp_req_if.
`timescale 1ns / 1ps
`default_nettype none

module hgrp_front (
    hgrp_req_if.sink      req,
    input  wire logic     q_full,
    output hgrp_pkg::item_t push_item,
    output logic          push
);
    import hgrp_pkg::*;

    assign req.ready = !q_full;
    assign push      = req.valid && !q_full;

    always_comb
    begin
        push_item.restart  = (req.kind == KIND_RESTART);
        push_item.low      = low_case(req.data_byte);
        push_item.blank    = (req.data_byte == CH_SPACE) || (req.data_byte == CH_TAB);
        push_item.cr       = (req.data_byte == CH_CR);
        push_item.lf       = (req.data_byte == CH_LF);
        push_item.nul      = (req.data_byte == CH_NUL);
        push_item.slash    = (req.data_byte == CH_SLASH);
        push_item.letter_h = (low_case(req.data_byte) == CH_H);
    end

endmodule

`default_nettype wire

// ===== hdl/hgrp_queue.sv =====
// Short FIFO of classified requests between front end and engine.
// Depends on hgrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hgrp_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire hgrp_pkg::item_t push_item,
    input  wire logic            pop,
    output hgrp_pkg::item_t      pop_item,
    output logic                 full,
    output logic                 empty
);
    import hgrp_pkg::*;

    item_t                 entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg,  count_next;

    assign full     = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/hgrp_engine.sv =====
// Back end: runs the request-line and header parser on classified bytes
// and holds each result in an output register. Depends on hgrp_pkg, hgrp_res_if.
`timescale 1ns / 1ps
`default_nettype none

module hgrp_engine (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire hgrp_pkg::item_t item,
    input  wire logic            q_empty,
    output logic                 pop,
    hgrp_res_if.source           res
);
    import hgrp_pkg::*;

    phase_t                phase_reg,        phase_next;
    line_field_t           field_reg,        field_next;
    logic [3:0]            match_pos_reg,    match_pos_next;
    logic                  match_ok_reg,     match_ok_next;
    url_mode_t             url_mode_reg,     url_mode_next;
    logic                  slash_found_reg,  slash_found_next;
    logic                  cr_pending_reg,   cr_pending_next;
    logic                  has_nul_reg,      has_nul_next;
    logic                  line_start_reg,   line_start_next;
    logic [2:0]            host_pos_reg,     host_pos_next;
    logic                  host_flag_reg,    host_flag_next;
    logic [BYTE_CNT_W-1:0] byte_count_reg,   byte_count_next;
    status_t               final_reg,        final_next;
    logic                  line_end_next;

    logic                  res_valid_reg;
    status_t               res_status_reg;
    logic                  res_line_end_reg;
    logic                  res_in_headers_reg;
    logic                  res_host_reg;

    // Take a byte whenever the output register is free or being drained
    assign pop = !q_empty && (!res_valid_reg || res.ready);

    // Next state
    always_comb
    begin
        phase_next       = phase_reg;
        field_next       = field_reg;
        match_pos_next   = match_pos_reg;
        match_ok_next    = match_ok_reg;
        url_mode_next    = url_mode_reg;
        slash_found_next = slash_found_reg;
        cr_pending_next  = cr_pending_reg;
        has_nul_next     = has_nul_reg;
        line_start_next  = line_start_reg;
        host_pos_next    = host_pos_reg;
        host_flag_next   = host_flag_reg;
        byte_count_next  = byte_count_reg;
        final_next       = final_reg;
        line_end_next    = 1'b0;

        if (pop) begin
            if (item.restart) begin
                phase_next       = PH_REQUEST;
                field_next       = FLD_METHOD;
                match_pos_next   = '0;
                match_ok_next    = 1'b1;
                url_mode_next    = URL_NONE;
                slash_found_next = 1'b0;
                cr_pending_next  = 1'b0;
                has_nul_next     = 1'b0;
                line_start_next  = 1'b1;
                host_pos_next    = '0;
                host_flag_next   = 1'b0;
                byte_count_next  = '0;
                final_next       = ST_PENDING;
            end else if (final_reg == ST_PENDING) begin
                if (byte_count_reg >= BUFFER_LIMIT) begin
                    final_next = ST_OVERFLOW;
                end else begin
                    byte_count_next = byte_count_reg + 1'b1;
                    if (cr_pending_reg) begin
                        if (!item.lf) begin
                            final_next = ST_BAD;
                        end else begin
                            line_end_next = 1'b1;
                            if (phase_reg == PH_REQUEST) begin
                                if (field_reg == FLD_VERSION && match_ok_reg &&
                                    match_pos_reg == VER_LEN && url_mode_reg == URL_GOOD) begin
                                    phase_next = PH_HEADERS;
                                end else begin
                                    final_next = ST_BAD;
                                end
                            end else if (line_start_reg) begin
                                final_next = ST_COMPLETE;
                            end else if (match_ok_reg && host_pos_reg == HOST_LEN) begin
                                host_flag_next = 1'b1;
                            end
                            // Start a fresh line
                            field_next       = FLD_METHOD;
                            match_pos_next   = '0;
                            match_ok_next    = 1'b1;
                            url_mode_next    = URL_NONE;
                            slash_found_next = 1'b0;
                            cr_pending_next  = 1'b0;
                            has_nul_next     = 1'b0;
                            line_start_next  = 1'b1;
                            host_pos_next    = '0;
                        end
                    end else if (item.cr) begin
                        cr_pending_next = 1'b1;
                    end else if (item.lf) begin
                        final_next = ST_BAD;
                    end else if (!has_nul_reg) begin
                        if (item.nul) begin
                            has_nul_next = 1'b1;
                        end else if (phase_reg == PH_REQUEST) begin
                            case (field_reg)
                                FLD_METHOD:
                                begin
                                    if (item.blank) begin
                                        field_next = (match_ok_reg && match_pos_reg == GET_LEN)
                                                     ? FLD_BLANK1 : FLD_REJECT;
                                    end else if (match_pos_reg < GET_LEN &&
                                                 item.low == get_char(match_pos_reg[1:0])) begin
                                        match_pos_next = match_pos_reg + 1'b1;
                                    end else begin
                                        match_ok_next = 1'b0;
                                    end
                                end
                                FLD_BLANK1:
                                begin
                                    if (!item.blank) begin
                                        field_next     = FLD_URL;
                                        match_pos_next = '0;
                                        if (item.slash) begin
                                            url_mode_next = URL_GOOD;
                                        end else if (item.letter_h) begin
                                            url_mode_next  = URL_ABS;
                                            match_pos_next = 4'd1;
                                        end else begin
                                            url_mode_next = URL_BAD;
                                        end
                                    end
                                end
                                FLD_URL:
                                begin
                                    if (item.blank) begin
                                        url_mode_next = (url_mode_reg == URL_GOOD ||
                                                         (url_mode_reg == URL_ABS &&
                                                          match_pos_reg == ABS_LEN &&
                                                          slash_found_reg))
                                                        ? URL_GOOD : URL_BAD;
                                        field_next = FLD_BLANK2;
                                    end else if (url_mode_reg == URL_NONE) begin
                                        if (item.slash) begin
                                            url_mode_next = URL_GOOD;
                                        end else if (item.letter_h) begin
                                            url_mode_next  = URL_ABS;
                                            match_pos_next = 4'd1;
                                        end else begin
                                            url_mode_next = URL_BAD;
                                        end
                                    end else if (url_mode_reg == URL_ABS) begin
                                        if (match_pos_reg < ABS_LEN) begin
                                            if (item.low == abs_char(match_pos_reg[2:0])) begin
                                                match_pos_next = match_pos_reg + 1'b1;
                                            end else begin
                                                url_mode_next = URL_BAD;
                                            end
                                        end else if (item.slash) begin
                                            slash_found_next = 1'b1;
                                        end
                                    end
                                end
                                FLD_BLANK2:
                                begin
                                    if (!item.blank) begin
                                        field_next     = FLD_VERSION;
                                        match_pos_next = '0;
                                        match_ok_next  = 1'b1;
                                        if (item.low == ver_char(3'd0)) begin
                                            match_pos_next = 4'd1;
                                        end else begin
                                            match_ok_next = 1'b0;
                                        end
                                    end
                                end
                                FLD_VERSION:
                                begin
                                    if (match_pos_reg < VER_LEN &&
                                        item.low == ver_char(match_pos_reg[2:0])) begin
                                        match_pos_next = match_pos_reg + 1'b1;
                                    end else begin
                                        match_ok_next = 1'b0;
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end else begin
                            line_start_next = 1'b0;
                            if (match_ok_reg && host_pos_reg < HOST_LEN) begin
                                if (item.low == host_char(host_pos_reg)) begin
                                    host_pos_next = host_pos_reg + 1'b1;
                                end else begin
                                    match_ok_next = 1'b0;
                                end
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg       <= PH_REQUEST;
            field_reg       <= FLD_METHOD;
            match_pos_reg   <= '0;
            match_ok_reg    <= 1'b1;
            url_mode_reg    <= URL_NONE;
            slash_found_reg <= 1'b0;
            cr_pending_reg  <= 1'b0;
            has_nul_reg     <= 1'b0;
            line_start_reg  <= 1'b1;
            host_pos_reg    <= '0;
            host_flag_reg   <= 1'b0;
            byte_count_reg  <= '0;
            final_reg       <= ST_PENDING;
            res_valid_reg   <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            field_reg       <= field_next;
            match_pos_reg   <= match_pos_next;
            match_ok_reg    <= match_ok_next;
            url_mode_reg    <= url_mode_next;
            slash_found_reg <= slash_found_next;
            cr_pending_reg  <= cr_pending_next;
            has_nul_reg     <= has_nul_next;
            line_start_reg  <= line_start_next;
            host_pos_reg    <= host_pos_next;
            host_flag_reg   <= host_flag_next;
            byte_count_reg  <= byte_count_next;
            final_reg       <= final_next;
            if (pop) begin
                res_valid_reg <= 1'b1;
            end else if (res.ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Result register: load on every byte taken
    always_ff @(posedge clk)
    begin
        if (pop) begin
            res_status_reg     <= final_next;
            res_line_end_reg   <= line_end_next;
            res_in_headers_reg <= (phase_next == PH_HEADERS);
            res_host_reg       <= host_flag_next;
        end
    end

    // Outputs
    always_comb
    begin
        res.valid      = res_valid_reg;
        res.status     = res_status_reg;
        res.line_end   = res_line_end_reg;
        res.in_headers = res_in_headers_reg;
        res.host_seen  = res_host_reg;
    end

endmodule

`default_nettype wire
